FILE: rtl/tas_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tas_pkg: shared types and constants of the tile animation sequencer
// entry table sizes, operation and kind codes, and the state encoding
// ----------------------------------------------------------------------------
package tas_pkg;
	localparam int MaxEntries  = 16;
	localparam int MaxFrames   = 16;
	localparam int MaxAdvances = 64;
	localparam int EntW  = 4;
	localparam int SlotW = 4;
	localparam int LenW  = 5;
	localparam int FrmW  = EntW + SlotW;
	localparam int AdvW  = 7;

	typedef enum logic [2:0] {
		OP_ADD   = 3'd0,
		OP_WRITE = 3'd1,
		OP_CLEAR = 3'd2,
		OP_TICK  = 3'd3,
		OP_QUERY = 3'd4
	} op_t;

	localparam logic [1:0] KIND_LINEAR   = 2'd0;
	localparam logic [1:0] KIND_CIRCULAR = 2'd1;

	typedef enum logic [5:0] {
		ST_IDLE  = 6'b000001,
		ST_LOAD  = 6'b000010,
		ST_STEP  = 6'b000100,
		ST_STORE = 6'b001000,
		ST_QRD   = 6'b010000,
		ST_OUT   = 6'b100000
	} state_t;
endpackage
`default_nettype wire

FILE: rtl/tile_animation_sequencer.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tile_animation_sequencer: sprite frame animation timer
// table of animation entries advanced by ticks, queried for the shown tile
// ----------------------------------------------------------------------------
// Every transfer on the input gives exactly one result transfer. Add, write,
// clear and unknown operations go from the load state straight to the
// result. A query with a frame to show passes a further read state, as it
// reads the frame memory through a registered port. A tick walks the entries
// one at a time with one shared subtract and compare unit: per entry it loads
// its state, passes a step state for each frame advance (at most 64) and for
// the final compare, and stores back. The block takes no new item until the
// result has been transferred. Frame memories are not cleared, so a frame
// that is read before it has been written gives an undefined value.
module tile_animation_sequencer (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         in_valid,
	output logic        in_ready,
	input  wire  [2:0]  op,
	input  wire  [3:0]  entry,
	input  wire  [3:0]  frame_slot,
	input  wire  [4:0]  seq_length,
	input  wire  [1:0]  seq_kind,
	input  wire  [15:0] tile_value,
	input  wire  [15:0] frame_delay,
	input  wire  [15:0] tick_ms,
	output logic        out_valid,
	input  wire         out_ready,
	output logic [3:0]  entry_id,
	output logic [15:0] tile_out,
	output logic [1:0]  kind_out,
	output logic        tile_valid,
	output logic        error
);
	import tas_pkg::*;

	state_t state_q;

	// per-entry state in flip-flops, fixed-width small tables
	logic [LenW-1:0] len_q  [MaxEntries];
	logic [1:0]      kind_q [MaxEntries];
	logic [LenW-1:0] pos_q  [MaxEntries];
	logic [31:0]     time_q [MaxEntries];
	logic [LenW-1:0] count_q;

	// frame memories
	logic [15:0] tiles_mem  [MaxEntries*MaxFrames];
	logic [15:0] delays_mem [MaxEntries*MaxFrames];
	logic [15:0] tile_rd_q;
	logic [15:0] delay_rd_q;
	logic [FrmW-1:0] rd_addr;
	logic        wr_en;

	// captured item
	logic [2:0]  op_q;
	logic [3:0]  ent_q;
	logic [3:0]  slot_q;
	logic [4:0]  slen_q;
	logic [1:0]  skind_q;
	logic [15:0] tile_in_q;
	logic [15:0] delay_in_q;
	logic [15:0] ms_q;

	// tick walk registers
	logic [EntW-1:0] we_q;
	logic [32:0]     t_q;
	logic [LenW-1:0] wpos_q;
	logic [AdvW-1:0] steps_q;
	logic            moved_q;
	logic            rd_ok_q;

	// result registers
	logic [3:0]  id_q;
	logic [15:0] tout_q;
	logic [1:0]  kout_q;
	logic        tval_q;
	logic        err_q;
	logic        use_mem_q;

	logic [LenW-1:0] cur_len;
	logic [1:0]      cur_kind;
	logic [LenW-1:0] q_len;
	logic [LenW-1:0] q_pos;
	logic [LenW-1:0] q_fpos;
	logic [LenW-1:0] nxt_pos;
	logic            step_go;
	logic [32:0]     t_sub;
	logic            ent_bad;

	assign in_ready = (state_q == ST_IDLE);
	assign out_valid = (state_q == ST_OUT);
	assign entry_id = id_q;
	assign tile_out = use_mem_q ? tile_rd_q : tout_q;
	assign kind_out = kout_q;
	assign tile_valid = tval_q;
	assign error = err_q;

	assign cur_len  = len_q[we_q];
	assign cur_kind = kind_q[we_q];
	assign q_len    = len_q[ent_q];
	assign q_pos    = pos_q[ent_q];
	assign ent_bad  = ({1'b0, ent_q} >= count_q);
	// finished linear entries show their last frame
	assign q_fpos   = (q_pos >= q_len) ? q_len - 5'd1 : q_pos;

	// shared compare and subtract unit of the tick walk
	assign t_sub   = t_q - {17'd0, delay_rd_q};
	assign step_go = rd_ok_q && (wpos_q < cur_len) && (steps_q < AdvW'(MaxAdvances))
		&& (t_q >= {17'd0, delay_rd_q});
	always_comb begin
		nxt_pos = wpos_q + 5'd1;
		if (nxt_pos == cur_len && cur_kind == KIND_CIRCULAR)
			nxt_pos = '0;
	end

	// memory read address: next frame during the walk, queried frame otherwise
	always_comb begin
		if (state_q == ST_LOAD)
			rd_addr = {we_q, pos_q[we_q][SlotW-1:0]};
		else if (state_q == ST_STEP)
			rd_addr = {we_q, nxt_pos[SlotW-1:0]};
		else
			rd_addr = {ent_q, q_fpos[SlotW-1:0]};
	end

	assign wr_en = (state_q == ST_LOAD) && (op_q == OP_WRITE) && !ent_bad
		&& ({1'b0, slot_q} < q_len);

	always_ff @(posedge clk) begin
		if (wr_en) begin
			tiles_mem[{ent_q, slot_q}]  <= tile_in_q;
			delays_mem[{ent_q, slot_q}] <= delay_in_q;
		end
		tile_rd_q  <= tiles_mem[rd_addr];
		delay_rd_q <= delays_mem[rd_addr];
	end

	// per-entry state and walk datapath
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			op_q <= op; ent_q <= entry; slot_q <= frame_slot; slen_q <= seq_length;
			skind_q <= seq_kind; tile_in_q <= tile_value; delay_in_q <= frame_delay;
			ms_q <= tick_ms;
		end
		if (state_q == ST_LOAD && op_q == OP_ADD && count_q < LenW'(MaxEntries)) begin
			len_q[count_q[EntW-1:0]]  <= (slen_q > LenW'(MaxFrames)) ? LenW'(MaxFrames) : slen_q;
			kind_q[count_q[EntW-1:0]] <= skind_q;
			pos_q[count_q[EntW-1:0]]  <= '0;
			time_q[count_q[EntW-1:0]] <= '0;
		end
		if (state_q == ST_LOAD && op_q == OP_TICK) begin
			t_q     <= {1'b0, time_q[we_q]} + {17'd0, ms_q};
			wpos_q  <= pos_q[we_q];
			steps_q <= '0;
			moved_q <= 1'b0;
			rd_ok_q <= 1'b1;
		end
		if (state_q == ST_STEP && step_go) begin
			t_q     <= t_sub;
			wpos_q  <= nxt_pos;
			steps_q <= steps_q + 7'd1;
			moved_q <= 1'b1;
		end
		if (state_q == ST_STORE) begin
			pos_q[we_q]  <= wpos_q;
			time_q[we_q] <= moved_q ? 32'd0 : (t_q[32] ? 32'hFFFF_FFFF : t_q[31:0]);
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
			we_q <= '0;
			id_q <= '0; tout_q <= '0; kout_q <= '0; tval_q <= 1'b0; err_q <= 1'b0;
			use_mem_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						state_q <= ST_LOAD;
						we_q <= '0;
						id_q <= '0; tout_q <= '0; kout_q <= '0; tval_q <= 1'b0;
						err_q <= 1'b0; use_mem_q <= 1'b0;
					end
				end
				ST_LOAD: begin
					state_q <= ST_OUT;
					case (op_q)
						OP_ADD: begin
							if (count_q >= LenW'(MaxEntries)) err_q <= 1'b1;
							else begin
								id_q <= count_q[EntW-1:0];
								count_q <= count_q + 5'd1;
							end
						end
						OP_WRITE: err_q <= ent_bad || ({1'b0, slot_q} >= q_len);
						OP_CLEAR: count_q <= '0;
						OP_TICK: begin
							if ({1'b0, we_q} < count_q) state_q <= ST_STEP;
						end
						OP_QUERY: begin
							if (ent_bad) err_q <= 1'b1;
							else begin
								kout_q <= kind_q[ent_q];
								if (q_len == '0) err_q <= 1'b1;
								else if (q_pos < q_len || kind_q[ent_q] == KIND_LINEAR) begin
									tval_q <= 1'b1;
									use_mem_q <= 1'b1;
									state_q <= ST_QRD;
								end
							end
						end
						default: ;
					endcase
				end
				ST_STEP: begin
					if (!step_go) state_q <= ST_STORE;
				end
				ST_STORE: begin
					we_q <= we_q + 4'd1;
					if ({1'b0, we_q} == count_q - 5'd1 || we_q == 4'(MaxEntries - 1))
						state_q <= ST_OUT;
					else
						state_q <= ST_LOAD;
				end
				ST_QRD: state_q <= ST_OUT;
				ST_OUT: begin
					if (out_ready) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// checks
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= LenW'(MaxEntries)) else $error("entry count out of range");
	a_out_blocks_in: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !in_ready) else $error("input open while result pending");
	a_steps_cap: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_STEP |-> steps_q <= AdvW'(MaxAdvances)) else $error("advance cap broken");
	a_valid_no_err: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(tile_valid && error)) else $error("tile valid with error");
endmodule
`default_nettype wire
